// ===== src/mfpa_pkg.sv =====
// Shared constants, codes and control types of the framebuffer pixel block.
package mfpa_pkg;

    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 64;
    localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
    localparam int STORE_BYTES   = ROW_BYTES_MAX * MAX_HEIGHT;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 16;
    localparam int FW_W    = 8;
    localparam int FH_W    = 7;
    localparam int CFG_IW  = 1;
    localparam int CFG_DW  = 8;

    // Derived widths
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int CNT_W  = $clog2(STORE_BYTES + 1);
    localparam int RB_W   = $clog2(ROW_BYTES_MAX + 1);
    localparam int COL_W  = (ROW_BYTES_MAX > 1) ? $clog2(ROW_BYTES_MAX) : 1;
    localparam int YC_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IDX_W  = YC_W + RB_W;
    localparam int LEN_W  = RB_W + FH_W;

    // Register indexes and reset values
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [FW_W-1:0]   RESET_WIDTH      = 8'd128;
    localparam logic [FH_W-1:0]   RESET_HEIGHT     = 7'd64;

    localparam logic [7:0] BYTE_WHITE = 8'hff;
    localparam logic [7:0] BIT_MSB    = 8'h80;

    typedef enum logic [CMD_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } mfpa_op_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic load_addr;
        logic mem_rd;
        logic mem_wr;
        logic walk_step;
        logic load_result;
    } mfpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic is_write;
        logic go_mem;
        logic walk_done;
        logic out_busy;
    } mfpa_sts_t;

endpackage

// ===== src/mfpa_req_if.sv =====
// Request channel: command, coordinates and color with valid/ready.
interface mfpa_req_if;
    import mfpa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      color;

    modport source (output valid, output command, output x, output y, output color,
                    input ready);
    modport sink   (input valid, input command, input x, input y, input color,
                    output ready);
endinterface

// ===== src/mfpa_rsp_if.sv =====
// Response channel: pixel value and bounds flag with valid/ready.
interface mfpa_rsp_if;
    logic valid;
    logic ready;
    logic pixel;
    logic in_bounds;

    modport source (output valid, output pixel, output in_bounds, input ready);
    modport sink   (input valid, input pixel, input in_bounds, output ready);
endinterface

// ===== src/mono_framebuffer_pixel_access_top.sv =====
// Top level of the one-bit-per-pixel framebuffer with pixel access and clear.
//
// A 1024-byte store holds a monochrome frame of up to 128 x 64 pixels, rows packed
// MSB first, ceil(frame_width/8) bytes per row. Each request writes one pixel, reads
// one pixel or clears the frame in use to white, and yields exactly one response.
// Off-screen coordinates are ignored on write and read back as white with in_bounds
// low. Requests are served one at a time by a sequencer around a single-port byte
// store: an on-screen pixel read or write goes through address math, store read,
// read-modify-write and response load; an off-screen or unused command skips the
// store; a clear writes the ceil(w/8)*h bytes of the frame in use, as the clear
// walker writes one byte per cycle. After reset the same walker sweeps all 1024
// bytes to white, and no request is taken until it is done; configuration
// writes are taken at any time. A finished response sits in an output register, so
// the store stays free while the sink stalls. Write frame_width (index 0) and
// frame_height (index 1) only while the block has no request in flight; values above
// the maximum frame size saturate to it.
module mono_framebuffer_pixel_access_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mfpa_pkg::CFG_IW-1:0] cfg_index,
    input  logic [mfpa_pkg::CFG_DW-1:0] cfg_data,
    mfpa_req_if.sink                    req,
    mfpa_rsp_if.source                  rsp
);
    import mfpa_pkg::*;

    mfpa_cmd_t cmd;
    mfpa_sts_t sts;

    // Sequencer: owns the request handshake and steps the datapath
    mfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: registers, address math, store and response register
    mfpa_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_command   (req.command),
        .req_x         (req.x),
        .req_y         (req.y),
        .req_color     (req.color),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_pixel     (rsp.pixel),
        .rsp_in_bounds (rsp.in_bounds),
        .cmd           (cmd),
        .sts           (sts)
    );
endmodule

// ===== src/mfpa_datapath.sv =====
// Datapath: config registers, address math, byte store, clear walker and result register.
module mfpa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mfpa_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [mfpa_pkg::CFG_DW-1:0]    cfg_data,
    input  logic [mfpa_pkg::CMD_W-1:0]     req_command,
    input  logic signed [mfpa_pkg::COORD_W-1:0] req_x,
    input  logic signed [mfpa_pkg::COORD_W-1:0] req_y,
    input  logic                           req_color,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic                           rsp_pixel,
    output logic                           rsp_in_bounds,
    input  mfpa_pkg::mfpa_cmd_t            cmd,
    output mfpa_pkg::mfpa_sts_t            sts
);
    import mfpa_pkg::*;

    logic [FW_W-1:0]    frame_width_reg;
    logic [FH_W-1:0]    frame_height_reg;
    mfpa_op_t           op_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic               color_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [2:0]         bit_reg;
    logic               inb_reg;
    logic [7:0]         rd_data_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   walk_end_reg;
    logic               out_valid_reg;
    logic               out_pixel_reg;
    logic               out_inb_reg;
    logic [7:0]         mem [STORE_BYTES];

    logic [FW_W-1:0]    w_used;
    logic [FH_W-1:0]    h_used;
    logic [FW_W:0]      rb_sum;
    logic [RB_W-1:0]    row_bytes;
    logic               x_ok;
    logic               y_ok;
    logic               inb_now;
    logic [COL_W-1:0]   col;
    logic [YC_W-1:0]    uy;
    logic [IDX_W-1:0]   row_base;
    logic [ADDR_W-1:0]  addr_next;
    logic [LEN_W-1:0]   len_full;
    logic [CNT_W-1:0]   len_cap;
    logic [7:0]         bit_mask;
    logic [7:0]         wr_byte;
    logic               rd_bit;
    logic               walk_done;
    logic               walk_wr;
    logic               is_access;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                frame_width_reg <= cfg_data[FW_W-1:0];
            if (cfg_index == REG_FRAME_HEIGHT)
                frame_height_reg <= cfg_data[FH_W-1:0];
        end
    end

    // Frame geometry in use
    always_comb
    begin
        w_used    = (32'(frame_width_reg) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : frame_width_reg;
        h_used    = (32'(frame_height_reg) > MAX_HEIGHT) ? FH_W'(MAX_HEIGHT) : frame_height_reg;
        rb_sum    = {1'b0, w_used} + (FW_W + 1)'(7);
        row_bytes = RB_W'(rb_sum >> 3);
        x_ok      = !x_reg[COORD_W-1] && (x_reg < COORD_W'(w_used));
        y_ok      = !y_reg[COORD_W-1] && (y_reg < COORD_W'(h_used));
        inb_now   = x_ok && y_ok;
        col       = COL_W'(x_reg >> 3);
        uy        = YC_W'(y_reg);
        row_base  = IDX_W'(uy) * IDX_W'(row_bytes);
        addr_next = ADDR_W'(row_base + IDX_W'(col));
        len_full  = LEN_W'(row_bytes) * LEN_W'(h_used);
        len_cap   = (32'(len_full) > STORE_BYTES) ? CNT_W'(STORE_BYTES) : CNT_W'(len_full);
    end

    assign is_access = (op_reg == OP_WRITE) || (op_reg == OP_READ);

    // Item and address registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= mfpa_op_t'(req_command);
            x_reg     <= $unsigned(req_x);
            y_reg     <= $unsigned(req_y);
            color_reg <= req_color;
        end
        if (cmd.load_addr)
        begin
            addr_reg <= addr_next;
            bit_reg  <= x_reg[2:0];
            inb_reg  <= inb_now && is_access;
        end
    end

    // Clear walker; reset starts a full pass over the store
    assign walk_done = (count_reg >= walk_end_reg);
    assign walk_wr   = cmd.walk_step && !walk_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            walk_end_reg <= CNT_W'(STORE_BYTES);
        end
        else if (cmd.load_addr && (op_reg == OP_CLEAR))
        begin
            count_reg    <= '0;
            walk_end_reg <= len_cap;
        end
        else if (walk_wr)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Byte store
    assign bit_mask = BIT_MSB >> bit_reg;
    assign wr_byte  = color_reg ? (rd_data_reg | bit_mask) : (rd_data_reg & ~bit_mask);
    assign rd_bit   = |(rd_data_reg & bit_mask);

    always_ff @(posedge clk)
    begin
        if (walk_wr)
            mem[count_reg[ADDR_W-1:0]] <= BYTE_WHITE;
        else if (cmd.mem_wr)
            mem[addr_reg] <= wr_byte;
        if (cmd.mem_rd)
            rd_data_reg <= mem[addr_reg];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_result)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_pixel_reg <= (op_reg == OP_READ) && (!inb_reg || rd_bit);
            out_inb_reg   <= inb_reg;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp_pixel     = out_pixel_reg;
    assign rsp_in_bounds = out_inb_reg;

    assign sts.is_clear  = (op_reg == OP_CLEAR);
    assign sts.is_write  = (op_reg == OP_WRITE);
    assign sts.go_mem    = is_access && inb_now;
    assign sts.walk_done = walk_done;
    assign sts.out_busy  = out_valid_reg;

    a_pixel_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> (inb_reg && (op_reg == OP_WRITE)))
        else $error("pixel write outside frame or for wrong command");

    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_result))
        else $error("result appeared without a load");

    a_walker_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= walk_end_reg)
        else $error("clear walker ran past its end");
endmodule

// ===== src/mfpa_ctrl.sv =====
// Controller: one-hot sequencer for reset clear, pixel access and clear commands.
module mfpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mfpa_pkg::mfpa_sts_t sts,
    output mfpa_pkg::mfpa_cmd_t cmd
);
    import mfpa_pkg::*;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_ADDR   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_MODIFY = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_RESP   = 7'b1000000
    } mfpa_state_t;

    mfpa_state_t state_reg;
    mfpa_state_t state_next;
    logic        req_accept;

    assign req_ready  = (state_reg == S_IDLE);
    assign req_accept = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.load_item = req_valid;
                if (req_valid)
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.load_addr = 1'b1;
                priority if (sts.is_clear)
                    state_next = S_CLEAR;
                else if (sts.go_mem)
                    state_next = S_READ;
                else
                    state_next = S_RESP;
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                cmd.mem_wr = sts.is_write;
                state_next = S_RESP;
            end
            S_CLEAR:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.load_result = !sts.out_busy;
                if (!sts.out_busy)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    a_accept_to_addr: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (state_reg == S_ADDR))
        else $error("accepted request did not advance to address stage");

    a_read_then_modify: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_MODIFY))
        else $error("store read not followed by modify");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> !cmd.walk_step)
        else $error("pixel write and clear write in the same cycle");
endmodule

// ===== test/tb_mono_framebuffer_pixel_access_top.sv =====
// Testbench for the one-bit-per-pixel framebuffer: directed corners, random frames, stalls.
`timescale 1ns / 1ps

module tb_mono_framebuffer_pixel_access_top;
    import mfpa_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 6000000;
    localparam int ITEMS_PER_FRAME = 100;
    localparam int FRAME_SETTINGS  = 12;
    localparam int SETTLE_CYCLES   = 16;

    // One response as the block returns it
    typedef struct packed {
        logic pixel;
        logic in_bounds;
    } pixel_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;

    mfpa_req_if req_bus ();
    mfpa_rsp_if rsp_bus ();

    mono_framebuffer_pixel_access_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // Shadow copy of the frame store and the frame size registers
    logic [7:0]      frame_bytes [STORE_BYTES];
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    // Responses predicted for accepted requests, oldest first
    pixel_result_t pixel_results_due [$];

    int fault_count   = 0;
    int cycle_count   = 0;
    int burst_left    = 0;

    // Response-side stall state; a test asks for a long hold by bumping hold_requests
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int sink_mode     = 0;
    int mode_left     = 0;
    int sink_tick     = 0;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Width and height in use saturate at the maximum frame size
    function automatic int width_in_use();
        return (frame_width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(frame_width_reg);
    endfunction

    function automatic int height_in_use();
        return (frame_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_height_reg);
    endfunction

    // Apply one request to the shadow store and return the response it must produce
    function automatic pixel_result_t predict_pixel_access(
        input mfpa_op_t                  op,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic                      c
    );
        int            w;
        int            h;
        int            row_bytes;
        int            col;
        int            row;
        int            addr;
        int            fill;
        logic [7:0]    bit_mask;
        pixel_result_t res;
        w         = width_in_use();
        h         = height_in_use();
        row_bytes = (w + 7) / 8;
        col       = px;
        row       = py;
        res       = '0;
        case (op)
            OP_WRITE, OP_READ:
            begin
                if (col >= 0 && row >= 0 && col < w && row < h)
                begin
                    res.in_bounds = 1'b1;
                    addr          = col / 8 + row * row_bytes;
                    bit_mask      = BIT_MSB >> (col % 8);
                    if (addr < STORE_BYTES)
                    begin
                        if (op == OP_WRITE)
                            frame_bytes[addr] = c ? (frame_bytes[addr] | bit_mask)
                                                  : (frame_bytes[addr] & ~bit_mask);
                        else
                            res.pixel = |(frame_bytes[addr] & bit_mask);
                    end
                end
                else if (op == OP_READ)
                begin
                    // off screen reads back as white
                    res.pixel = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                // only the bytes of the frame in use go white
                fill = row_bytes * h;
                if (fill > STORE_BYTES)
                    fill = STORE_BYTES;
                for (int i = 0; i < fill; i++)
                    frame_bytes[i] = BYTE_WHITE;
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one request and hold it until taken. Bursts of random length are
    // separated by random gaps; some bursts run long with no gap at all.
    task automatic send_request(
        input mfpa_op_t                  op,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic                      c
    );
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
                gap = $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.command <= op;
        req_bus.x       <= px;
        req_bus.y       <= py;
        req_bus.color   <= c;
        do
            @(posedge clk);
        while (!req_bus.ready);
        pixel_results_due.push_back(predict_pixel_access(op, px, py, c));
    endtask

    // Drop valid, then hold until every predicted response has come back
    task automatic wait_all_results();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pixel_results_due.size() != 0)
            @(posedge clk);
    endtask

    // Write one frame size register; only called while nothing is in flight
    task automatic write_frame_reg(input logic [CFG_IW-1:0] index,
                                   input logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        if (index == REG_FRAME_WIDTH)
            frame_width_reg = data[FW_W-1:0];
        else if (index == REG_FRAME_HEIGHT)
            frame_height_reg = data[FH_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly on-screen reads and writes so the store fills with black pixels
    // that later reads can see; the rest probes the edges, random off-screen
    // points, clears and the unused command.
    task automatic send_random_request();
        int                        w;
        int                        h;
        int                        pick;
        mfpa_op_t                  op;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        w    = width_in_use();
        h    = height_in_use();
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op = OP_CLEAR;
        else if (pick < 5)
            op = OP_NONE;
        else if (pick < 50)
            op = OP_WRITE;
        else
            op = OP_READ;
        pick = $urandom_range(0, 99);
        if (pick < 80 && w > 0 && h > 0)
        begin
            px = COORD_W'($urandom_range(0, w - 1));
            py = COORD_W'($urandom_range(0, h - 1));
        end
        else if (pick < 88)
        begin
            // full 16-bit range, exercises every coordinate bit
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
        end
        else if (pick < 94)
        begin
            px = COORD_W'($urandom_range(0, 1) ? w + $urandom_range(0, 2)
                                               : -1 - $urandom_range(0, 2));
            py = (h > 0) ? COORD_W'($urandom_range(0, h - 1)) : '0;
        end
        else
        begin
            px = (w > 0) ? COORD_W'($urandom_range(0, w - 1)) : '0;
            py = COORD_W'($urandom_range(0, 1) ? h + $urandom_range(0, 2)
                                               : -1 - $urandom_range(0, 2));
        end
        send_request(op, px, py, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Response side: stall pattern and checker
    // ------------------------------------------------------------------

    // Switch between always-ready, random stalls and a fixed one-in-four stall.
    // A requested hold keeps ready low without a break until hold_left runs down.
    always @(negedge clk)
    begin
        sink_tick++;
        if (hold_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                sink_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 200);
            end
            else
                mode_left--;
            case (sink_mode)
                0:       rsp_bus.ready <= 1'b1;
                1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                default: rsp_bus.ready <= (sink_tick % 4 != 0);
            endcase
        end
    end

    // Compare each taken response with the oldest prediction
    always @(posedge clk)
    begin : check_response
        pixel_result_t due;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pixel_results_due.size() == 0)
            begin
                $error("response with no request outstanding: pixel %0b in_bounds %0b",
                       rsp_bus.pixel, rsp_bus.in_bounds);
                fault_count++;
            end
            else
            begin
                due = pixel_results_due.pop_front();
                if (rsp_bus.pixel !== due.pixel)
                begin
                    $error("pixel: expected %0b, actual %0b", due.pixel, rsp_bus.pixel);
                    fault_count++;
                end
                if (rsp_bus.in_bounds !== due.in_bounds)
                begin
                    $error("in_bounds: expected %0b, actual %0b",
                           due.in_bounds, rsp_bus.in_bounds);
                    fault_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[mono_framebuffer_pixel_access_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Frame corners at the reset size: byte edges, last pixel, just off the right,
    // bottom and left edges, extreme coordinates, the unused command and a clear.
    task automatic test_pixel_corners();
        send_request(OP_READ,  0,   0,  1'b0);
        send_request(OP_WRITE, 0,   0,  1'b0);
        send_request(OP_READ,  0,   0,  1'b1);
        send_request(OP_WRITE, 7,   0,  1'b0);
        send_request(OP_READ,  7,   0,  1'b0);
        send_request(OP_WRITE, 8,   0,  1'b0);
        send_request(OP_READ,  8,   0,  1'b0);
        send_request(OP_WRITE, 127, 63, 1'b0);
        send_request(OP_READ,  127, 63, 1'b0);
        send_request(OP_READ,  128, 0,  1'b0);
        send_request(OP_READ,  0,   64, 1'b0);
        send_request(OP_READ,  -1,  0,  1'b0);
        send_request(OP_WRITE, 16'sh8000, 16'sh7fff, 1'b0);
        send_request(OP_READ,  16'sh7fff, 16'sh8000, 1'b1);
        send_request(OP_NONE,  -1,  0,  1'b1);
        send_request(OP_WRITE, 0,   0,  1'b1);
        send_request(OP_READ,  0,   0,  1'b0);
        send_request(OP_CLEAR, 0,   0,  1'b0);
        send_request(OP_READ,  127, 63, 1'b0);
        send_request(OP_READ,  8,   0,  1'b0);
        wait_all_results();
    endtask

    // Zero width, zero height, row layout change and saturating sizes
    task automatic test_frame_special_cases();
        // zero width: nothing is on screen, clear touches nothing
        write_frame_reg(REG_FRAME_WIDTH, 8'd0);
        send_request(OP_READ,  0, 0, 1'b0);
        send_request(OP_WRITE, 0, 0, 1'b0);
        send_request(OP_CLEAR, 0, 0, 1'b0);
        wait_all_results();
        // zero height
        write_frame_reg(REG_FRAME_WIDTH, 8'd5);
        write_frame_reg(REG_FRAME_HEIGHT, 8'd0);
        send_request(OP_READ,  0, 0, 1'b0);
        send_request(OP_CLEAR, 0, 0, 1'b0);
        wait_all_results();
        // 5 x 3 frame: one byte per row, so (4, 2) lands in byte 2
        write_frame_reg(REG_FRAME_HEIGHT, 8'd3);
        send_request(OP_WRITE, 4, 2, 1'b0);
        send_request(OP_READ,  4, 2, 1'b0);
        wait_all_results();
        // oversized registers saturate; height data above 7 bits is cut off,
        // and byte 2 now holds pixel (20, 0)
        write_frame_reg(REG_FRAME_WIDTH, 8'hff);
        write_frame_reg(REG_FRAME_HEIGHT, 8'hff);
        send_request(OP_READ,  20,  0,  1'b1);
        send_request(OP_WRITE, 127, 63, 1'b0);
        send_request(OP_READ,  127, 63, 1'b0);
        send_request(OP_READ,  128, 63, 1'b0);
        wait_all_results();
    endtask

    // Hold the response side for a long stretch while requests keep coming,
    // so the block fills up and drops ready on its input
    task automatic test_input_backpressure();
        write_frame_reg(REG_FRAME_WIDTH, 8'd16);
        write_frame_reg(REG_FRAME_HEIGHT, 8'd8);
        hold_requests++;
        repeat (30) send_random_request();
        wait_all_results();
    endtask

    // Random traffic over a series of frame sizes, extremes first
    task automatic test_random_frames();
        int widths  [FRAME_SETTINGS] = '{128, 1, 8, 9, 255, 129, 16, 127, 3, 0, 0, 0};
        int heights [FRAME_SETTINGS] = '{64, 1, 1, 2, 127, 65, 64, 63, 40, 0, 0, 0};
        for (int k = 0; k < FRAME_SETTINGS; k++)
        begin
            if (widths[k] == 0)
            begin
                widths[k]  = $urandom_range(1, 255);
                heights[k] = $urandom_range(1, 127);
            end
            write_frame_reg(REG_FRAME_WIDTH, 8'(widths[k]));
            // top data bit is ignored by the height register; toggle it anyway
            write_frame_reg(REG_FRAME_HEIGHT,
                            {1'($urandom_range(0, 1)), 7'(heights[k])});
            repeat (ITEMS_PER_FRAME) send_random_request();
            wait_all_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        req_bus.valid   = 1'b0;
        req_bus.command = OP_WRITE;
        req_bus.x       = '0;
        req_bus.y       = '0;
        req_bus.color   = 1'b0;
        rsp_bus.ready   = 1'b0;
        foreach (frame_bytes[i])
            frame_bytes[i] = BYTE_WHITE;
        frame_width_reg  = RESET_WIDTH;
        frame_height_reg = RESET_HEIGHT;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the block sweeps its store after reset; send_request waits on ready
        test_pixel_corners();
        test_frame_special_cases();
        test_input_backpressure();
        test_random_frames();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("[mono_framebuffer_pixel_access_top] OK");
        else
            $display("[mono_framebuffer_pixel_access_top] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mfpa_pkg.sv
src/mfpa_req_if.sv
src/mfpa_rsp_if.sv
src/mfpa_datapath.sv
src/mfpa_ctrl.sv
src/mono_framebuffer_pixel_access_top.sv
test/tb_mono_framebuffer_pixel_access_top.sv
